// File: sv/wtsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types and constants for the world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int CLIP_W = 50;  // clip sum width
  localparam int D_W    = 48;  // divisor / magnitude width
  localparam int N_W    = 64;  // magnitude times size
  localparam int Q_W    = 34;  // quotient bits kept
  localparam int FRAC_W = 15;  // extra quotient scale (half size in Q16.16)

  typedef enum logic [2:0] {
    REG_ROW_X_LO = 3'd0,
    REG_ROW_X_HI = 3'd1,
    REG_ROW_Y_LO = 3'd2,
    REG_ROW_Y_HI = 3'd3,
    REG_ROW_W_LO = 3'd4,
    REG_ROW_W_HI = 3'd5,
    REG_VIEWPORT = 3'd6,
    REG_MIN_DEPTH = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        vis;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] wpx;
    logic [15:0] hpx;
  } meta_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } row_t;

endpackage

// File: sv/wtsp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_in_if
// World point channel.
// ----------------------------------------------------------------------------
interface wtsp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

// File: sv/wtsp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_out_if
// Screen point channel.
// ----------------------------------------------------------------------------
interface wtsp_out_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;

  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

// File: sv/wtsp_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_clip
// Matrix rows times world point: products, then floored sums (2 stages).
// ----------------------------------------------------------------------------
module wtsp_clip
  import wtsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [31:0]       x,
  input  logic signed [31:0]       y,
  input  logic signed [31:0]       z,
  input  row_t                     row_x,
  input  row_t                     row_y,
  input  row_t                     row_w,
  output logic                     valid,
  output logic signed [CLIP_W-1:0] cx,
  output logic signed [CLIP_W-1:0] cy,
  output logic signed [CLIP_W-1:0] cw
);

  logic               v1_r, v2_r;
  logic signed [63:0] p_r [0:8];
  logic signed [63:0] p_nxt [0:8];
  logic signed [CLIP_W-1:0] cx_r, cy_r, cw_r;

  function automatic logic signed [CLIP_W-1:0] fl(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    return s[CLIP_W-1:0];
  endfunction

  function automatic logic signed [CLIP_W-1:0] tr(input logic [63:0] hi);
    return CLIP_W'($signed(hi[63:32]));
  endfunction

  always_comb begin
    p_nxt[0] = $signed(row_x.lo[31:0])  * x;
    p_nxt[1] = $signed(row_x.lo[63:32]) * y;
    p_nxt[2] = $signed(row_x.hi[31:0])  * z;
    p_nxt[3] = $signed(row_y.lo[31:0])  * x;
    p_nxt[4] = $signed(row_y.lo[63:32]) * y;
    p_nxt[5] = $signed(row_y.hi[31:0])  * z;
    p_nxt[6] = $signed(row_w.lo[31:0])  * x;
    p_nxt[7] = $signed(row_w.lo[63:32]) * y;
    p_nxt[8] = $signed(row_w.hi[31:0])  * z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) p_r[i] <= p_nxt[i];
      cx_r <= fl(p_r[0]) + fl(p_r[1]) + fl(p_r[2]) + tr(row_x.hi);
      cy_r <= fl(p_r[3]) + fl(p_r[4]) + fl(p_r[5]) + tr(row_y.hi);
      cw_r <= fl(p_r[6]) + fl(p_r[7]) + fl(p_r[8]) + tr(row_w.hi);
    end
  end

  assign valid = v2_r;
  assign cx    = cx_r;
  assign cy    = cy_r;
  assign cw    = cw_r;

endmodule

// File: sv/wtsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_div
// Visibility test, scaling, then a restoring divider with one quotient bit
// per stage for both axes against the shared clip W.
// ----------------------------------------------------------------------------
module wtsp_div
  import wtsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [CLIP_W-1:0] cx,
  input  logic signed [CLIP_W-1:0] cy,
  input  logic signed [CLIP_W-1:0] cw,
  input  logic [31:0]              viewport,
  input  logic [30:0]              min_depth,
  output logic                     valid,
  output meta_t                    meta,
  output logic                     ovf_x,
  output logic                     ovf_y,
  output logic [Q_W-1:0]           qx,
  output logic [Q_W-1:0]           qy
);

  // stage A: visibility and magnitudes
  logic            va_r;
  meta_t           ma_r;
  logic [D_W-1:0]  mx_r, my_r, da_r;
  logic signed [CLIP_W-1:0] md_s;
  logic signed [CLIP_W-1:0] ax, ay;

  assign md_s = $signed({{(CLIP_W-31){1'b0}}, min_depth});
  assign ax   = cx[CLIP_W-1] ? -cx : cx;
  assign ay   = cy[CLIP_W-1] ? -cy : cy;

  // stage B: products
  logic            vb_r;
  meta_t           mb_r;
  logic [D_W-1:0]  db_r;
  logic [N_W-1:0]  nx_r, ny_r;

  // divider stages
  logic           vs_r [0:Q_W];
  meta_t          ms_r [0:Q_W];
  logic [D_W-1:0] ds_r [0:Q_W];
  logic           ox_r [0:Q_W];
  logic           oy_r [0:Q_W];
  logic [D_W-1:0] rx_r [0:Q_W];
  logic [D_W-1:0] ry_r [0:Q_W];
  logic [Q_W-1:0] lx_r [0:Q_W];
  logic [Q_W-1:0] ly_r [0:Q_W];
  logic [Q_W-1:0] qx_r [0:Q_W];
  logic [Q_W-1:0] qy_r [0:Q_W];

  logic [D_W-1:0] rx_nxt [0:Q_W-1];
  logic [D_W-1:0] ry_nxt [0:Q_W-1];
  logic           gx [0:Q_W-1];
  logic           gy [0:Q_W-1];

  always_comb begin
    for (int s = 0; s < Q_W; s++) begin
      logic [D_W:0] tx, ty;
      tx = {rx_r[s], lx_r[s][Q_W-1]};
      ty = {ry_r[s], ly_r[s][Q_W-1]};
      gx[s] = tx >= {1'b0, ds_r[s]};
      gy[s] = ty >= {1'b0, ds_r[s]};
      rx_nxt[s] = gx[s] ? D_W'(tx - {1'b0, ds_r[s]}) : tx[D_W-1:0];
      ry_nxt[s] = gy[s] ? D_W'(ty - {1'b0, ds_r[s]}) : ty[D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      for (int s = 0; s <= Q_W; s++) vs_r[s] <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vs_r[0] <= vb_r;
      for (int s = 0; s < Q_W; s++) vs_r[s+1] <= vs_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r.vis   <= (cw >= md_s) && (cw > 0);
      ma_r.neg_x <= cx[CLIP_W-1];
      ma_r.neg_y <= cy[CLIP_W-1];
      ma_r.wpx   <= viewport[15:0];
      ma_r.hpx   <= viewport[31:16];
      mx_r <= ax[D_W-1:0];
      my_r <= ay[D_W-1:0];
      da_r <= cw[D_W-1:0];

      mb_r <= ma_r;
      db_r <= da_r;
      nx_r <= mx_r * ma_r.wpx;
      ny_r <= my_r * ma_r.hpx;

      // quotient of (n << 15) / d; top bits beyond Q_W flag overflow
      ms_r[0] <= mb_r;
      ds_r[0] <= db_r;
      ox_r[0] <= {{(D_W-(N_W-(Q_W-FRAC_W))){1'b0}}, nx_r[N_W-1:Q_W-FRAC_W]} >= db_r;
      oy_r[0] <= {{(D_W-(N_W-(Q_W-FRAC_W))){1'b0}}, ny_r[N_W-1:Q_W-FRAC_W]} >= db_r;
      rx_r[0] <= D_W'(nx_r[N_W-1:Q_W-FRAC_W]);
      ry_r[0] <= D_W'(ny_r[N_W-1:Q_W-FRAC_W]);
      lx_r[0] <= {nx_r[Q_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      ly_r[0] <= {ny_r[Q_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      qx_r[0] <= '0;
      qy_r[0] <= '0;

      for (int s = 0; s < Q_W; s++) begin
        ms_r[s+1] <= ms_r[s];
        ds_r[s+1] <= ds_r[s];
        ox_r[s+1] <= ox_r[s];
        oy_r[s+1] <= oy_r[s];
        rx_r[s+1] <= rx_nxt[s];
        ry_r[s+1] <= ry_nxt[s];
        lx_r[s+1] <= {lx_r[s][Q_W-2:0], 1'b0};
        ly_r[s+1] <= {ly_r[s][Q_W-2:0], 1'b0};
        qx_r[s+1] <= {qx_r[s][Q_W-2:0], gx[s]};
        qy_r[s+1] <= {qy_r[s][Q_W-2:0], gy[s]};
      end
    end
  end

  assign valid = vs_r[Q_W];
  assign meta  = ms_r[Q_W];
  assign ovf_x = ox_r[Q_W];
  assign ovf_y = oy_r[Q_W];
  assign qx    = qx_r[Q_W];
  assign qy    = qy_r[Q_W];

endmodule

// File: sv/world_to_screen_projection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// Perspective projection of Q16.16 world points to saturated pixel coordinates.
// ----------------------------------------------------------------------------
// Accepts one point per cycle unless stalled and returns one result per point,
// in order, after two stages of matrix multiply and sum, two of visibility
// and scaling, one divider setup stage, 34 restoring-divider stages (one
// quotient bit each) and the output register. The whole pipeline advances
// together and holds when the output register is full and not taken.
// Configuration writes must only occur while the pipeline is empty.
module world_to_screen_projection_unit
  import wtsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wtsp_in_if.sink     in_ch,
  wtsp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  row_t        row_x_r, row_y_r, row_w_r;
  logic [31:0] viewport_r;
  logic [30:0] min_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r     <= '0;
      row_y_r     <= '0;
      row_w_r     <= '0;
      viewport_r  <= 32'd70780800;
      min_depth_r <= 31'd66;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_X_LO:  row_x_r.lo  <= cfg_wdata;
        REG_ROW_X_HI:  row_x_r.hi  <= cfg_wdata;
        REG_ROW_Y_LO:  row_y_r.lo  <= cfg_wdata;
        REG_ROW_Y_HI:  row_y_r.hi  <= cfg_wdata;
        REG_ROW_W_LO:  row_w_r.lo  <= cfg_wdata;
        REG_ROW_W_HI:  row_w_r.hi  <= cfg_wdata;
        REG_VIEWPORT:  viewport_r  <= cfg_wdata[31:0];
        REG_MIN_DEPTH: min_depth_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  logic                     c_valid;
  logic signed [CLIP_W-1:0] cx, cy, cw;

  wtsp_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .x        (in_ch.world_x),
    .y        (in_ch.world_y),
    .z        (in_ch.world_z),
    .row_x    (row_x_r),
    .row_y    (row_y_r),
    .row_w    (row_w_r),
    .valid    (c_valid),
    .cx       (cx),
    .cy       (cy),
    .cw       (cw)
  );

  logic           d_valid, ovf_x, ovf_y;
  meta_t          meta;
  logic [Q_W-1:0] qx, qy;

  wtsp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid),
    .cx        (cx),
    .cy        (cy),
    .cw        (cw),
    .viewport  (viewport_r),
    .min_depth (min_depth_r),
    .valid     (d_valid),
    .meta      (meta),
    .ovf_x     (ovf_x),
    .ovf_y     (ovf_y),
    .qx        (qx),
    .qy        (qy)
  );

  localparam int S_W = Q_W + 3;
  localparam logic signed [S_W-1:0] S_MAX = S_W'(64'sd2147483647);
  localparam logic signed [S_W-1:0] S_MIN = S_W'(-64'sd2147483648);

  logic signed [S_W-1:0] bx, by, sqx, sqy, sx, sy;
  logic signed [31:0]    scr_x, scr_y;

  always_comb begin
    bx  = $signed({{(S_W-31){1'b0}}, meta.wpx, {FRAC_W{1'b0}}});
    by  = $signed({{(S_W-31){1'b0}}, meta.hpx, {FRAC_W{1'b0}}});
    sqx = $signed({3'b000, qx});
    sqy = $signed({3'b000, qy});
    sx  = meta.neg_x ? bx - sqx : bx + sqx;
    sy  = meta.neg_y ? by + sqy : by - sqy;
    if (ovf_x)          scr_x = meta.neg_x ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else if (sx > S_MAX) scr_x = 32'sh7fff_ffff;
    else if (sx < S_MIN) scr_x = 32'sh8000_0000;
    else                 scr_x = sx[31:0];
    if (ovf_y)          scr_y = meta.neg_y ? 32'sh7fff_ffff : 32'sh8000_0000;
    else if (sy > S_MAX) scr_y = 32'sh7fff_ffff;
    else if (sy < S_MIN) scr_y = 32'sh8000_0000;
    else                 scr_y = sy[31:0];
    if (!meta.vis) begin
      scr_x = '0;
      scr_y = '0;
    end
  end

  logic               vis_r;
  logic signed [31:0] scr_x_r, scr_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r   <= meta.vis;
      scr_x_r <= scr_x;
      scr_y_r <= scr_y;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.visible  = vis_r;
  assign out_ch.screen_x = scr_x_r;
  assign out_ch.screen_y = scr_y_r;

endmodule

// File: sv/wtsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_checker
// Port-level checks for the projection unit, bound to the top level.
// ----------------------------------------------------------------------------
module wtsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        visible,
  input logic [31:0] screen_x,
  input logic [31:0] screen_y
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !visible |-> screen_x == 32'd0 && screen_y == 32'd0)
    else $error("hidden point with nonzero coordinates");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
      && $stable(visible))
    else $error("stalled transfer changed");

endmodule

bind world_to_screen_projection_unit wtsp_checker u_wtsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .visible   (out_ch.visible),
  .screen_x  (out_ch.screen_x),
  .screen_y  (out_ch.screen_y)
);
